// ----- hdl/mbe_pkg.sv -----
package mbe_pkg;

	// coordinate format of c
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 28;

	// z carries two more integer bits than c
	localparam int ZW   = COORD_WIDTH + 2;
	// the multiplier splits the second operand into a low and a high half
	localparam int HALF = ZW / 2;
	localparam int BW   = HALF + 1;
	localparam int PW   = ZW + BW;
	// full product and floored square widths
	localparam int FW   = 2 * ZW;
	localparam int XW   = FW - FRAC_BITS;

	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(255);

	// escape threshold 4.0, one bit wider than a square so the sum fits
	localparam logic [XW:0] FOUR = (XW + 1)'(1) << (FRAC_BITS + 2);

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_LIMIT = '0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EVAL
	} state_t;

	typedef enum logic [1:0] {
		OP_XX,
		OP_YY,
		OP_XY
	} op_t;

	typedef enum logic [1:0] {
		MP_IDLE,
		MP_LO,
		MP_HI,
		MP_SUM
	} mul_ph_t;

	typedef struct packed {
		logic                 start;
		logic signed [ZW-1:0] a;
		logic signed [ZW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [FW-1:0] prod;
	} mul_rsp_t;

endpackage

// ----- hdl/mbe_point_if.sv -----
interface mbe_point_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [mbe_pkg::COORD_WIDTH-1:0]   point_re;
	logic signed [mbe_pkg::COORD_WIDTH-1:0]   point_im;

	modport source (output valid, output point_re, output point_im, input ready);
	modport sink (input valid, input point_re, input point_im, output ready);
endinterface

// ----- hdl/mbe_count_if.sv -----
interface mbe_count_if;
	logic                            valid;
	logic                            ready;
	logic [mbe_pkg::COUNT_W-1:0]     iteration_count;

	modport source (output valid, output iteration_count, input ready);
	modport sink (input valid, input iteration_count, output ready);
endinterface

// ----- hdl/mbe_regs.sv -----
module mbe_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mbe_pkg::APB_AW-1:0]   paddr,
	input  logic [mbe_pkg::APB_DW-1:0]   pwdata,
	output logic [mbe_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output logic [mbe_pkg::COUNT_W-1:0]  limit
);

	logic [mbe_pkg::COUNT_W-1:0] limit_q;
	logic                        sel_limit;

	assign pready    = 1'b1;
	assign sel_limit = (paddr[mbe_pkg::APB_AW-1:2] == mbe_pkg::REG_LIMIT);
	assign limit     = limit_q;
	assign prdata    = sel_limit ? mbe_pkg::APB_DW'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= mbe_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && sel_limit) begin
			limit_q <= pwdata[mbe_pkg::COUNT_W-1:0];
		end
	end

endmodule

// ----- hdl/mbe_mul.sv -----
module mbe_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mbe_pkg::mul_req_t req,
	output mbe_pkg::mul_rsp_t rsp
);

	mbe_pkg::mul_ph_t ph_q, ph_d;

	logic signed [mbe_pkg::ZW-1:0] a_q, b_q;
	logic signed [mbe_pkg::BW-1:0] b_lo, b_hi, b_sel;
	logic signed [mbe_pkg::PW-1:0] p_d, p_q, lo_q;

	// b = b_hi * 2^HALF + b_lo, low half taken as unsigned
	assign b_lo  = $signed({1'b0, b_q[mbe_pkg::HALF-1:0]});
	assign b_hi  = mbe_pkg::BW'($signed(b_q[mbe_pkg::ZW-1:mbe_pkg::HALF]));
	assign b_sel = (ph_q == mbe_pkg::MP_LO) ? b_lo : b_hi;
	assign p_d   = mbe_pkg::PW'(a_q) * mbe_pkg::PW'(b_sel);

	assign rsp.done = (ph_q == mbe_pkg::MP_SUM);
	assign rsp.prod = mbe_pkg::FW'(lo_q) + (mbe_pkg::FW'(p_q) <<< mbe_pkg::HALF);

	always_comb begin
		ph_d = ph_q;
		case (ph_q)
			mbe_pkg::MP_IDLE: begin
				if (req.start) ph_d = mbe_pkg::MP_LO;
			end
			mbe_pkg::MP_LO:  ph_d = mbe_pkg::MP_HI;
			mbe_pkg::MP_HI:  ph_d = mbe_pkg::MP_SUM;
			mbe_pkg::MP_SUM: begin
				ph_d = req.start ? mbe_pkg::MP_LO : mbe_pkg::MP_IDLE;
			end
			default: ph_d = mbe_pkg::MP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= mbe_pkg::MP_IDLE;
		end else begin
			ph_q <= ph_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		if (ph_q == mbe_pkg::MP_LO || ph_q == mbe_pkg::MP_HI) begin
			p_q <= p_d;
		end
		// hold the low partial product while the high one is formed
		if (ph_q == mbe_pkg::MP_HI) begin
			lo_q <= p_q;
		end
	end

endmodule

// ----- hdl/mbe_seq.sv -----
module mbe_seq (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [mbe_pkg::COORD_WIDTH-1:0] point_re,
	input  logic signed [mbe_pkg::COORD_WIDTH-1:0] point_im,
	input  logic [mbe_pkg::COUNT_W-1:0]           limit,
	output mbe_pkg::mul_req_t                     mul_req,
	input  mbe_pkg::mul_rsp_t                     mul_rsp,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mbe_pkg::COUNT_W-1:0]           out_count
);

	localparam int EXT = mbe_pkg::ZW - mbe_pkg::COORD_WIDTH;

	mbe_pkg::state_t state_q, state_d;
	mbe_pkg::op_t    op_q, op_nx;

	logic signed [mbe_pkg::COORD_WIDTH-1:0] cr_q, ci_q;
	logic signed [mbe_pkg::ZW-1:0]          zx_q, zy_q, xy_q;
	logic [mbe_pkg::XW-1:0]                 xx_q, yy_q;
	logic [mbe_pkg::COUNT_W-1:0]            count_q, out_count_q;
	logic                                   out_valid_q;

	logic signed [mbe_pkg::ZW-1:0] cr_ext, ci_ext, zx_new, zy_new, zx_src, zy_src;
	logic signed [mbe_pkg::FW-1:0] sq_shift, xy_shift;
	logic [mbe_pkg::XW:0]          sq_sum;
	logic                          escaped, finished, out_free;
	logic                          accept, store, update, load_out;

	assign cr_ext = {{EXT{cr_q[mbe_pkg::COORD_WIDTH-1]}}, cr_q};
	assign ci_ext = {{EXT{ci_q[mbe_pkg::COORD_WIDTH-1]}}, ci_q};

	// floored products
	assign sq_shift = mul_rsp.prod >>> mbe_pkg::FRAC_BITS;
	assign xy_shift = mul_rsp.prod >>> (mbe_pkg::FRAC_BITS - 1);

	// squares are never negative, so the sum is compared unsigned
	assign sq_sum   = {1'b0, xx_q} + {1'b0, yy_q};
	assign escaped  = (sq_sum >= mbe_pkg::FOUR);
	assign finished = (count_q >= limit) || escaped;
	assign out_free = !out_valid_q || out_ready;

	// the update is used only when both squares are below 4.0, so it fits in ZW bits
	assign zx_new = $signed(xx_q[mbe_pkg::ZW-1:0]) - $signed(yy_q[mbe_pkg::ZW-1:0]) + cr_ext;
	assign zy_new = xy_q + ci_ext;

	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_count = out_count_q;

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		mul_req.start = 1'b0;
		op_nx         = mbe_pkg::OP_XX;
		zx_src        = zx_q;
		zy_src        = zy_q;
		store         = 1'b0;
		update        = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				zx_src   = '0;
				zy_src   = '0;
				if (in_valid) begin
					mul_req.start = 1'b1;
					state_d       = mbe_pkg::ST_MUL;
				end
			end
			mbe_pkg::ST_MUL: begin
				if (mul_rsp.done) begin
					store = 1'b1;
					case (op_q)
						mbe_pkg::OP_XX: begin
							mul_req.start = 1'b1;
							op_nx         = mbe_pkg::OP_YY;
						end
						mbe_pkg::OP_YY: begin
							mul_req.start = 1'b1;
							op_nx         = mbe_pkg::OP_XY;
						end
						default: state_d = mbe_pkg::ST_EVAL;
					endcase
				end
			end
			mbe_pkg::ST_EVAL: begin
				if (finished) begin
					// hold here while the previous result is still unread
					if (out_free) begin
						load_out = 1'b1;
						state_d  = mbe_pkg::ST_IDLE;
					end
				end else begin
					update        = 1'b1;
					mul_req.start = 1'b1;
					zx_src        = zx_new;
					zy_src        = zy_new;
					state_d       = mbe_pkg::ST_MUL;
				end
			end
			default: state_d = mbe_pkg::ST_IDLE;
		endcase
		mul_req.a = (op_nx == mbe_pkg::OP_YY) ? zy_src : zx_src;
		mul_req.b = (op_nx == mbe_pkg::OP_XX) ? zx_src : zy_src;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbe_pkg::ST_IDLE;
			op_q        <= mbe_pkg::OP_XX;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_req.start) op_q <= op_nx;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cr_q    <= point_re;
			ci_q    <= point_im;
			zx_q    <= '0;
			zy_q    <= '0;
			count_q <= '0;
		end
		if (update) begin
			zx_q    <= zx_new;
			zy_q    <= zy_new;
			count_q <= count_q + mbe_pkg::COUNT_W'(1);
		end
		if (store) begin
			case (op_q)
				mbe_pkg::OP_XX: xx_q <= sq_shift[mbe_pkg::XW-1:0];
				mbe_pkg::OP_YY: yy_q <= sq_shift[mbe_pkg::XW-1:0];
				default:        xy_q <= xy_shift[mbe_pkg::ZW-1:0];
			endcase
		end
		if (load_out) out_count_q <= count_q;
	end

endmodule

// ----- hdl/mandelbrot_escape_iteration.sv -----
// Mandelbrot escape-time unit. Each transaction on point carries c in signed Q4.28; the block
// iterates z = z*z + c from z = 0 while |z|^2 < 4.0 and the count is below iteration_limit
// (APB register at address 0, reset 255) and returns the count on result. One shared
// multiplier forms each of zx*zx, zy*zy and zx*zy in two partial products, so one iteration
// runs the three products one after another, then an evaluation step for the escape test and
// update. A point occupies the block until it finishes, after which the next point is taken;
// the result sits in an output register, so a stalled result delays the next point only if a
// second result is ready before the first is taken.
module mandelbrot_escape_iteration (
	input  logic                         clk,
	input  logic                         arst_n,
	mbe_point_if.sink                    point,
	mbe_count_if.source                  result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mbe_pkg::APB_AW-1:0]   paddr,
	input  logic [mbe_pkg::APB_DW-1:0]   pwdata,
	output logic [mbe_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	logic [mbe_pkg::COUNT_W-1:0] limit;
	mbe_pkg::mul_req_t           mul_req;
	mbe_pkg::mul_rsp_t           mul_rsp;

	mbe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limit   (limit)
	);

	mbe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	mbe_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.in_ready  (point.ready),
		.point_re  (point.point_re),
		.point_im  (point.point_im),
		.limit     (limit),
		.mul_req   (mul_req),
		.mul_rsp   (mul_rsp),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_count (result.iteration_count)
	);

endmodule

// ----- hdl/mbe_checker.sv -----
module mbe_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mbe_pkg::COUNT_W-1:0] out_count
);

	// one point at a time: drop ready right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("point accepted while busy");

	// a full iteration round finishes before the block can take another point
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##9 !in_ready)
		else $error("block ready before first iteration round completed");

	// a result is produced only while a point is in work
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared with no point in work");

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_count)))
		else $error("stalled result changed or dropped");

endmodule

bind mandelbrot_escape_iteration mbe_checker u_mbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (point.valid),
	.in_ready  (point.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_count (result.iteration_count)
);

// ----- sim/mandelbrot_escape_iteration_tb.sv -----
`timescale 1ns / 1ps

module mandelbrot_escape_iteration_tb;

	localparam int CLK_HALF     = 5;
	localparam int TIMEOUT_NS   = 200_000_000;
	localparam int NUM_PHASES   = 7;
	localparam int PHASE_ITEMS  = 190;
	localparam int HOLD_CYCLES  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS  = 10;
	// deep-limit phase: send only points that escape within this many iterations
	localparam int ESCAPE_CAP   = 200;
	localparam int Q_ONE        = 1 << mbe_pkg::FRAC_BITS;

	typedef logic signed [mbe_pkg::COORD_WIDTH-1:0] coord_t;

	class escape_scoreboard;
		int unsigned limit;
		int unsigned expected_counts[$];
		int unsigned failures;

		function new();
			limit = 32'(mbe_pkg::LIMIT_RESET);
			failures = 0;
		endfunction

		// fixed-point escape time of c = re + i*im, squares floored, 2xy via shift by FRAC_BITS-1
		function int unsigned escape_count(coord_t re, coord_t im, int unsigned iter_cap);
			longint cr, ci, zx, zy, xx, yy, xy2;
			logic signed [127:0] prod;
			int unsigned n;
			cr = longint'(re);
			ci = longint'(im);
			zx = 0;
			zy = 0;
			n = 0;
			while (n < iter_cap) begin
				prod = 128'(zx) * 128'(zx);
				xx = longint'(prod >>> mbe_pkg::FRAC_BITS);
				prod = 128'(zy) * 128'(zy);
				yy = longint'(prod >>> mbe_pkg::FRAC_BITS);
				if (xx + yy >= (longint'(4) << mbe_pkg::FRAC_BITS))
					break;
				prod = 128'(zx) * 128'(zy);
				xy2 = longint'(prod >>> (mbe_pkg::FRAC_BITS - 1));
				zx = xx - yy + cr;
				zy = xy2 + ci;
				n++;
			end
			return n;
		endfunction

		function void note_point(coord_t re, coord_t im);
			expected_counts.push_back(escape_count(re, im, limit));
		endfunction

		function void check_count(logic [mbe_pkg::COUNT_W-1:0] got);
			logic [mbe_pkg::COUNT_W-1:0] want;
			if (expected_counts.size() == 0) begin
				if (failures < MAX_REPORTS)
					$display("%0t: unexpected result, iteration_count=%0d", $realtime, got);
				failures++;
				return;
			end
			want = mbe_pkg::COUNT_W'(expected_counts.pop_front());
			if (got !== want) begin
				if (failures < MAX_REPORTS)
					$display("%0t: iteration_count mismatch, expected %0d, actual %0d",
						$realtime, want, got);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return expected_counts.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [mbe_pkg::APB_AW-1:0] paddr;
	logic [mbe_pkg::APB_DW-1:0] pwdata;
	logic [mbe_pkg::APB_DW-1:0] prdata;
	logic pready;

	bit idle_on;
	bit hold_request;

	mbe_point_if point_if ();
	mbe_count_if count_if ();

	escape_scoreboard escape_sb;

	mandelbrot_escape_iteration dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.point   (point_if),
		.result  (count_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

	task automatic write_limit(input logic [mbe_pkg::COUNT_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {mbe_pkg::REG_LIMIT, 2'b00};
		pwdata <= mbe_pkg::APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		escape_sb.limit = 32'(value);
	endtask

	// offer one point until the transaction completes, then maybe idle for a burst
	task automatic send_point(input coord_t re, input coord_t im);
		point_if.valid <= 1'b1;
		point_if.point_re <= re;
		point_if.point_im <= im;
		do
			@(posedge clk);
		while (!point_if.ready);
		escape_sb.note_point(re, im);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			point_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (point_if.valid)
			point_if.valid <= 1'b0;
		while (escape_sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic pick_point(output coord_t re, output coord_t im);
		int specials[6];
		int sel;
		coord_t t;
		specials = '{0, 1, -1, 32'h7fffffff, 32'h80000000, Q_ONE / 4};
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			re = $urandom;
			im = $urandom;
		end else if (sel < 8) begin
			// window around the set, re in [-2.1, 0.6], im in [-1.3, 1.3]
			re = -563714458 + int'($urandom_range(0, 724775731));
			im = -348966093 + int'($urandom_range(0, 697932186));
		end else if (sel == 8) begin
			// straddle the radius-2 circle on an axis
			re = ($urandom_range(0, 1) ? 2 : -2) * Q_ONE + int'($urandom_range(0, 4095)) - 2048;
			im = int'($urandom_range(0, 8191)) - 4096;
			if ($urandom_range(0, 1)) begin
				t = re;
				re = im;
				im = t;
			end
		end else begin
			re = specials[$urandom_range(0, 5)];
			im = specials[$urandom_range(0, 5)];
		end
	endtask

	// result side: random ready bursts, a long hold-off on request, steady in the last phase
	initial begin : result_sink
		int burst_left;
		int hold_left;
		bit burst_ready;
		burst_left = 0;
		hold_left = 0;
		burst_ready = 1'b1;
		count_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (count_if.valid && count_if.ready)
				escape_sb.check_count(count_if.iteration_count);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				count_if.ready <= 1'b0;
			end else if (!idle_on) begin
				count_if.ready <= 1'b1;
			end else begin
				if (burst_left == 0) begin
					burst_ready = $urandom_range(0, 2) != 0;
					burst_left = $urandom_range(1, 11);
				end
				burst_left--;
				count_if.ready <= burst_ready;
			end
		end
	end

	initial begin : stimulus
		int dir_re[20];
		int dir_im[20];
		logic [mbe_pkg::COUNT_W-1:0] phase_limits[NUM_PHASES];
		coord_t re, im;
		int unsigned bound;

		escape_sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		point_if.valid = 1'b0;
		point_if.point_re = '0;
		point_if.point_im = '0;
		idle_on = 1'b1;
		hold_request = 1'b0;

		dir_re = '{0, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			-2 * Q_ONE, 2 * Q_ONE, 0, Q_ONE / 4, Q_ONE / 4 + 1,
			-201326592, -Q_ONE, 0, 0, 1,
			-471070433, -27139319, Q_ONE / 2, -2 * Q_ONE - 1, 379625062};
		dir_im = '{0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			0, 0, 2 * Q_ONE, 0, 0,
			26843546, 0, Q_ONE, -Q_ONE, -1,
			0, 256703528, Q_ONE / 2, 0, 379625062};
		// zero and full-scale limits are the extremes; the last phase runs without idling
		phase_limits = '{16'd0, 16'd1, 16'd7, 16'd40, 16'd255, 16'hFFFF, 16'd100};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed points at the reset limit
		foreach (dir_re[i])
			send_point(coord_t'(dir_re[i]), coord_t'(dir_im[i]));

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_limit(phase_limits[p]);
			idle_on = (p != NUM_PHASES - 1);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 1 && k == 40)
					hold_request = 1'b1;
				pick_point(re, im);
				// keep the run short at the full-scale limit: skip points that stay bounded
				if (phase_limits[p] > ESCAPE_CAP) begin
					bound = ESCAPE_CAP + 1;
					while (phase_limits[p] == 16'hFFFF
							&& escape_sb.escape_count(re, im, bound) > ESCAPE_CAP)
						pick_point(re, im);
				end
				send_point(re, im);
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (escape_sb.failures == 0 && escape_sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- mandelbrot_escape_iteration.f -----
hdl/mbe_pkg.sv
hdl/mbe_point_if.sv
hdl/mbe_count_if.sv
hdl/mbe_regs.sv
hdl/mbe_mul.sv
hdl/mbe_seq.sv
hdl/mandelbrot_escape_iteration.sv
hdl/mbe_checker.sv
sim/mandelbrot_escape_iteration_tb.sv
